// ===== rtl/vbgm_pkg.sv =====
`timescale 1ns / 1ps
package vbgm_pkg;

  typedef struct packed {
    logic        func;
    logic [2:0]  status;
    logic [15:0] delay;
    logic [15:0] round_trip_delay;
    logic [15:0] jb_nominal;
    logic [15:0] jb_abs_max;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  loss_rate;
    logic [7:0]  discard_rate;
    logic [7:0]  burst_density;
    logic [7:0]  gap_density;
    logic [15:0] burst_duration;
    logic [15:0] gap_duration;
    logic [15:0] rtt_out;
    logic [15:0] jb_nominal_out;
    logic [15:0] jb_max_seen;
    logic [15:0] jb_abs_max_out;
  } out_item_t;

  localparam int unsigned NumW = 64;
  localparam int unsigned DivCntW = 6;

  localparam logic [0:0] RegGapMin = 1'd0;
  localparam logic [0:0] RegFrameDur = 1'd1;

  localparam logic [2:0] StNormal = 3'd0;
  localparam logic [2:0] StLost = 3'd1;
  localparam logic [2:0] StLate = 3'd2;
  localparam logic [2:0] StDiscard = 3'd3;
  localparam logic [2:0] StDup = 3'd4;
  localparam logic [2:0] StOther = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_FOLD, S_LOSS, S_DISC, S_BDEN, S_GDEN, S_GAP, S_BURST, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/vbgm_div.sv =====
`timescale 1ns / 1ps
module vbgm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vbgm_pkg::NumW-1:0]     num,
  input  logic [vbgm_pkg::NumW-1:0]     den,
  output logic                          busy,
  output logic                          done,
  output logic [vbgm_pkg::NumW-1:0]     quo
);
  import vbgm_pkg::*;

  logic [NumW-1:0]    rem;
  logic [NumW-1:0]    dvs;
  logic [DivCntW-1:0] cnt;
  logic [NumW:0]      trial;

  // One quotient bit per cycle, restoring division.
  assign trial = {rem, quo[NumW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        if (!trial[NumW]) begin
          rem <= trial[NumW-1:0];
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= {rem[NumW-2:0], quo[NumW-1]};
          quo <= {quo[NumW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(NumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == DivCntW'(NumW - 1)) |=> done)
    else $error("divider missed done");
`endif
endmodule

// ===== rtl/voip_burst_gap_metrics.sv =====
`timescale 1ns / 1ps
// VoIP burst/gap metrics, RFC 3611 style Markov counters.
// Input requests come on in_valid/in_ready with an in_item_t payload.
// A packet event (func 0) is taken in S_IDLE and gives no result, so packet
// events can follow each other back to back.
// A report (func 1) gives one out_item_t request on out_valid/out_ready.
// A report first folds the open good run (S_FOLD), then runs six divisions
// one after another through one bit-serial 64-bit divider, and the result
// shows in S_OUT and is held there until out_ready.
// The block takes one request at a time; in_ready is low while it works
// and while a result waits, so a stalled receiver stalls the input.
// Registers are written on cfg_we with cfg_index and cfg_data; users must
// write them only when the block is idle (not enforced). Index 0 is Gmin,
// index 1 the frame duration in ms. Synchronous reset clears all counters
// and restores Gmin 16 and 20 ms. A report only folds the good run into
// c11; the counters wrap at 32 bits. Rates and densities saturate at 255,
// durations at 65535, and a zero denominator gives zero.
module voip_burst_gap_metrics (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vbgm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vbgm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import vbgm_pkg::*;

  state_t state, state_next;
  logic [7:0]  gmin, fdur;
  logic [31:0] good_run, lib, c11, c13, c14, c22, c23, c33, lost, disc;
  logic [15:0] maxd;
  in_item_t    req;
  logic        pend;

  logic            dstart, dbusy, ddone;
  logic [NumW-1:0] dnum, dden, dquo;
  div_ctl_t        dctl;
  logic [NumW-1:0] ctotal, gapq;

  vbgm_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .busy(dbusy), .done(ddone), .quo(dquo)
  );
  assign dctl = '{start: dstart, busy: dbusy, done: ddone};

  assign ctotal = NumW'(c11) + NumW'(c14) + (NumW'(c13) << 1) + NumW'(c22)
                + (NumW'(c23) << 1) + NumW'(c33);

  function automatic logic [7:0] sat8(input logic [NumW-1:0] v);
    sat8 = (v > NumW'(255)) ? 8'd255 : v[7:0];
  endfunction
  function automatic logic [15:0] sat16(input logic [NumW-1:0] v);
    sat16 = (v > NumW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  // Operand select for the division of the current step; x*255 = (x<<8)-x.
  logic [NumW-1:0] bsum, dd;
  always_comb begin
    bsum = NumW'(c13) + NumW'(c23) + NumW'(c33);
    dd   = (c13 == '0) ? NumW'(1) : NumW'(c13);
    dnum = '0;
    dden = '0;
    unique case (state)
      S_LOSS:  begin dnum = (NumW'(lost) << 8) - NumW'(lost); dden = ctotal; end
      S_DISC:  begin dnum = (NumW'(disc) << 8) - NumW'(disc); dden = ctotal; end
      S_BDEN:  begin
        dnum = (bsum << 8) - bsum;
        dden = (c23 == '0) ? '0 : NumW'(c22) + NumW'(c23) + bsum;
      end
      S_GDEN:  begin
        dnum = (NumW'(c14) << 8) - NumW'(c14);
        dden = NumW'(c11) + NumW'(c14);
      end
      S_GAP:   begin
        dnum = (NumW'(c11) + NumW'(c14) + NumW'(c13)) * NumW'(fdur);
        dden = dd;
      end
      S_BURST: begin dnum = ctotal * NumW'(fdur); dden = dd; end
      default: ;
    endcase
  end

  // The divider returns all ones for a zero divisor; such a ratio is zero.
  logic [NumW-1:0] dres;
  assign dres = (dden == '0) ? '0 : dquo;

  // Start the divider on entry to each divide step.
  always_comb begin
    dstart = 1'b0;
    if (!dbusy && !ddone && !pend) begin
      dstart = (state == S_LOSS) || (state == S_DISC) || (state == S_BDEN)
            || (state == S_GDEN) || (state == S_GAP) || (state == S_BURST);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = in_data.func ? S_FOLD : S_IDLE;
      S_FOLD:  state_next = S_LOSS;
      S_LOSS:  if (ddone) state_next = S_DISC;
      S_DISC:  if (ddone) state_next = S_BDEN;
      S_BDEN:  if (ddone) state_next = S_GDEN;
      S_GDEN:  if (ddone) state_next = S_GAP;
      S_GAP:   if (ddone) state_next = S_BURST;
      S_BURST: if (ddone) state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
  end

  logic bad, isl, isd;
  always_comb begin
    isl = (in_data.status == StLost);
    isd = (in_data.status == StLate) || (in_data.status == StDiscard)
       || (in_data.status == StDup);
    bad = isl || isd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gmin <= 8'd16; fdur <= 8'd20;
      good_run <= '0; lib <= '0; c11 <= '0; c13 <= '0; c14 <= '0;
      c22 <= '0; c23 <= '0; c33 <= '0; lost <= '0; disc <= '0;
      maxd <= '0; pend <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= dstart;
      if (cfg_we) begin
        if (cfg_index == RegGapMin) gmin <= cfg_data;
        if (cfg_index == RegFrameDur) fdur <= cfg_data;
      end
      if (state == S_IDLE && in_valid) begin
        req <= in_data;
        if (!in_data.func) begin
          if (isl) lost <= lost + 1'b1;
          if (isd) disc <= disc + 1'b1;
          if (!bad) begin
            good_run <= good_run + 1'b1;
          end else begin
            if (good_run >= 32'(gmin)) begin
              if (lib == 32'd1) c14 <= c14 + 1'b1;
              else c13 <= c13 + 1'b1;
              lib <= 32'd1;
              c11 <= c11 + good_run;
            end else begin
              lib <= lib + 1'b1;
              if (good_run == '0) c33 <= c33 + 1'b1;
              else begin
                c23 <= c23 + 1'b1;
                c22 <= c22 + good_run - 1'b1;
              end
            end
            good_run <= '0;
          end
          if (in_data.status == StNormal && in_data.delay > maxd) maxd <= in_data.delay;
        end
      end
      if (state == S_FOLD) begin
        c11 <= c11 + good_run;
        good_run <= '0;
      end
      if (ddone) begin
        unique case (state)
          S_LOSS:  out_data.loss_rate <= sat8(dres);
          S_DISC:  out_data.discard_rate <= sat8(dres);
          S_BDEN:  out_data.burst_density <= sat8(dres);
          S_GDEN:  out_data.gap_density <= sat8(dres);
          S_GAP:   begin gapq <= dres; out_data.gap_duration <= sat16(dres); end
          S_BURST: out_data.burst_duration <= sat16((dres >= gapq) ? dres - gapq : '0);
          default: ;
        endcase
      end
      if (state == S_FOLD) begin
        out_data.rtt_out <= req.round_trip_delay;
        out_data.jb_nominal_out <= req.jb_nominal;
        out_data.jb_abs_max_out <= req.jb_abs_max;
        out_data.jb_max_seen <= maxd;
      end
    end
  end

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready while busy");
  a_div_only_work: assert property (@(posedge clk) disable iff (rst)
    dctl.start |-> (state != S_IDLE && state != S_OUT && state != S_FOLD))
    else $error("divider started outside a divide step");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
`endif
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import vbgm_pkg::*;

  localparam int unsigned StallLimit = 20000;

  // Tracks the burst/gap counters and queues the metrics each report should give.
  class metrics_board;
    bit [31:0] good_run, lost_in_burst, c11, c13, c14, c22, c23, c33;
    bit [31:0] lost_total, discarded_total;
    bit [15:0] max_delay;
    bit [7:0] gmin, frame_ms;
    out_item_t pending[$];
    int errors;

    function void clear();
      good_run = 0; lost_in_burst = 0; c11 = 0; c13 = 0; c14 = 0;
      c22 = 0; c23 = 0; c33 = 0; lost_total = 0; discarded_total = 0;
      max_delay = 0; gmin = 8'd16; frame_ms = 8'd20;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, bit [7:0] val);
      if (idx == RegGapMin) gmin = val;
      else frame_ms = val;
    endfunction

    function bit [63:0] sat_div(bit [63:0] num, bit [63:0] den, bit [63:0] cap);
      bit [63:0] q;
      if (den == 0) return 0;
      q = num / den;
      return (q > cap) ? cap : q;
    endfunction

    function void note_request(in_item_t it);
      bit bad;
      bit [63:0] ctotal, a, b, d, f, gap_raw, burst_all, burst_raw;
      out_item_t r;
      if (it.func == 1'b0) begin
        bad = 0;
        if (it.status == StLost) begin
          lost_total++;
          bad = 1;
        end else if (it.status == StLate || it.status == StDiscard || it.status == StDup) begin
          discarded_total++;
          bad = 1;
        end
        if (!bad) good_run++;
        else begin
          if (good_run >= gmin) begin
            if (lost_in_burst == 1) c14++;
            else c13++;
            lost_in_burst = 1;
            c11 += good_run;
          end else begin
            lost_in_burst++;
            if (good_run == 0) c33++;
            else begin
              c23++;
              c22 += good_run - 1;
            end
          end
          good_run = 0;
        end
        if (it.status == StNormal && it.delay > max_delay) max_delay = it.delay;
        return;
      end
      c11 += good_run;
      good_run = 0;
      ctotal = 64'(c11) + c14 + 2 * 64'(c13) + c22 + 2 * 64'(c23) + c33;
      r.loss_rate = 8'(sat_div(255 * 64'(lost_total), ctotal, 255));
      r.discard_rate = 8'(sat_div(255 * 64'(discarded_total), ctotal, 255));
      if (c23 == 0) r.burst_density = 0;
      else begin
        a = 64'(c22) + c23;
        b = 64'(c13) + c23 + c33;
        r.burst_density = 8'(sat_div(255 * b, a + b, 255));
      end
      r.gap_density = 8'(sat_div(255 * 64'(c14), 64'(c11) + c14, 255));
      d = (c13 == 0) ? 1 : 64'(c13);
      f = frame_ms;
      gap_raw = (64'(c11) + c14 + c13) * f / d;
      burst_all = ctotal * f / d;
      burst_raw = (burst_all >= gap_raw) ? burst_all - gap_raw : 0;
      r.burst_duration = (burst_raw > 64'hFFFF) ? 16'hFFFF : 16'(burst_raw);
      r.gap_duration = (gap_raw > 64'hFFFF) ? 16'hFFFF : 16'(gap_raw);
      r.rtt_out = it.round_trip_delay;
      r.jb_nominal_out = it.jb_nominal;
      r.jb_max_seen = max_delay;
      r.jb_abs_max_out = it.jb_abs_max;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.loss_rate !== e.loss_rate) begin
        $error("loss_rate exp %0d got %0d", e.loss_rate, got.loss_rate); errors++;
      end
      if (got.discard_rate !== e.discard_rate) begin
        $error("discard_rate exp %0d got %0d", e.discard_rate, got.discard_rate); errors++;
      end
      if (got.burst_density !== e.burst_density) begin
        $error("burst_density exp %0d got %0d", e.burst_density, got.burst_density); errors++;
      end
      if (got.gap_density !== e.gap_density) begin
        $error("gap_density exp %0d got %0d", e.gap_density, got.gap_density); errors++;
      end
      if (got.burst_duration !== e.burst_duration) begin
        $error("burst_duration exp %0d got %0d", e.burst_duration, got.burst_duration);
        errors++;
      end
      if (got.gap_duration !== e.gap_duration) begin
        $error("gap_duration exp %0d got %0d", e.gap_duration, got.gap_duration); errors++;
      end
      if (got.rtt_out !== e.rtt_out) begin
        $error("rtt_out exp %0d got %0d", e.rtt_out, got.rtt_out); errors++;
      end
      if (got.jb_nominal_out !== e.jb_nominal_out) begin
        $error("jb_nominal_out exp %0d got %0d", e.jb_nominal_out, got.jb_nominal_out);
        errors++;
      end
      if (got.jb_max_seen !== e.jb_max_seen) begin
        $error("jb_max_seen exp %0d got %0d", e.jb_max_seen, got.jb_max_seen); errors++;
      end
      if (got.jb_abs_max_out !== e.jb_abs_max_out) begin
        $error("jb_abs_max_out exp %0d got %0d", e.jb_abs_max_out, got.jb_abs_max_out);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  metrics_board board;
  int send_idle_pct, recv_idle_pct;
  int unsigned quiet_cycles;
  bit pending_at_start;

  voip_burst_gap_metrics uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stalls, checks every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Valid stays high after an accepted request until the next idle cycle,
  // so requests can follow back to back.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(it);
  endtask

  task automatic packet(bit [2:0] st, bit [15:0] dly);
    in_item_t it;
    it = '0;
    it.status = st;
    it.delay = dly;
    it.round_trip_delay = 16'($urandom);
    it.jb_nominal = 16'($urandom);
    it.jb_abs_max = 16'($urandom);
    send(it);
  endtask

  task automatic report(bit [15:0] rtt, bit [15:0] nom, bit [15:0] amax);
    in_item_t it;
    it.func = 1'b1;
    it.status = 3'($urandom);
    it.delay = 16'($urandom);
    it.round_trip_delay = rtt;
    it.jb_nominal = nom;
    it.jb_abs_max = amax;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, bit [7:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: good runs with loss or discard bursts.
  task automatic random_phase(int n);
    int i, k;
    bit [2:0] st;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 6) report(16'($urandom), 16'($urandom), 16'($urandom));
      else begin
        if (k < 60) st = ($urandom_range(3) == 0) ? StOther : StNormal;
        else if (k < 75) st = StLost;
        else if (k < 95) st = 3'($urandom_range(2, 4));
        else st = 3'($urandom_range(5, 7));
        packet(st, ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    board = new();
    board.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegGapMin;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: report on empty counters (zero denominators), every status,
    // delay extremes, a burst then long gap, then isolated losses.
    report(16'h0000, 16'hFFFF, 16'h0000);
    packet(StNormal, 16'hFFFF);
    packet(StNormal, 16'h0000);
    packet(StLost, 16'h1234);
    packet(StLate, 16'hFFFF);
    packet(StDiscard, 16'h0001);
    packet(StDup, 16'h0002);
    packet(StOther, 16'hFFFF);
    packet(3'd6, 16'hFFFF);
    packet(3'd7, 16'h0000);
    report(16'hFFFF, 16'h0000, 16'hFFFF);
    repeat (17) packet(StNormal, 16'd5);
    packet(StLost, 16'd0);
    report(16'h5555, 16'hAAAA, 16'h5A5A);
    drain();

    write_reg(RegGapMin, 8'd1);
    write_reg(RegFrameDur, 8'd255);
    for (p = 0; p < 3; p++) begin
      packet(StNormal, 16'd9);
      packet(StLost, 16'd0);
    end
    report(16'd1, 16'd2, 16'd3);
    drain();

    write_reg(RegGapMin, 8'd255);
    write_reg(RegFrameDur, 8'd1);
    send_idle_pct = 28;
    recv_idle_pct = 66;
    random_phase(400);
    report(16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    write_reg(RegGapMin, 8'($urandom_range(1, 8)));
    write_reg(RegFrameDur, 8'($urandom_range(1, 255)));
    send_idle_pct = 66;
    recv_idle_pct = 28;
    random_phase(400);
    report(16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    write_reg(RegGapMin, 8'd16);
    write_reg(RegFrameDur, 8'd20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(420);
    report(16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    pending_at_start = (board.pending.size() != 0);
    if (board.errors == 0 && !pending_at_start) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
